[rtl/i2a_pkg.sv]
// i2a_pkg: shared types, constants and helpers for integer_to_ascii_formatter.
// Depends on nothing; used by i2a_cell and the top level.
package i2a_pkg;

    // Format selector codes
    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_HEXL = 3'd2;
    localparam logic [2:0] OP_HEXU = 3'd3;
    localparam logic [2:0] OP_PTR  = 3'd4;

    // Sizing of the digit row
    localparam int POINTER_BITS = 64;
    localparam int WORD_BITS    = 32;
    localparam int PTR_DIGITS   = (POINTER_BITS + 3) / 4;
    localparam int DEC_DIGITS   = 10;
    localparam int NCELL        = (PTR_DIGITS > DEC_DIGITS) ? PTR_DIGITS : DEC_DIGITS;
    localparam int CHAIN_BITS   = NCELL * 4;
    localparam int LEFT_W       = $clog2(NCELL + 1);
    localparam int CNT_W        = 5;
    localparam int BITS_W       = $clog2(WORD_BITS);

    // ASCII codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_A_UP  = 8'h41;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] value;
    } t_in;

    typedef struct packed {
        logic [7:0]       character;
        logic             last;
        logic [CNT_W-1:0] char_count;
    } t_out;

    // Per-cycle command to every cell of the row
    typedef struct packed {
        logic load;   // take a parallel digit
        logic conv;   // add-3 correct, then shift one bit up
        logic shift;  // take the lower neighbor's digit
    } t_cell_ctl;

    // Digit to ASCII, hex letters in either case
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        begin
            if (d < 4'd10) begin
                digit_char = CH_ZERO + {4'b0, d};
            end else begin
                base       = upper ? CH_A_UP : CH_A_LO;
                digit_char = base + {4'b0, d} - 8'd10;
            end
        end
    endfunction

endpackage

[rtl/integer_to_ascii_formatter.sv]
// Decimal: a bit-serial conversion pass (ST_CONV) over the word, then NCELL (16) digit
// positions (ST_DIG). Hex: the NCELL digit positions only; pointer first adds the "0x"
// prefix (ST_PFX). A new number is taken only while idle; the bit-serial pass through
// the cell row and one cell shift per digit position set the length of the busy period.
// Results are registered and appear in the cycle after they are formed; no stall exists.
// Synchronous active-low reset returns the sequencer to idle and drops the strobe.
module integer_to_ascii_formatter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  i2a_pkg::t_in  i_item,
    output logic          o_strobe,
    output i2a_pkg::t_out o_result
);
    import i2a_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_PFX, ST_DIG} t_state;

    t_state              r_state;
    logic [WORD_BITS-1:0] r_bin;
    logic [BITS_W-1:0]   r_bits;
    logic [LEFT_W-1:0]   r_left;
    logic [CNT_W-1:0]    r_count;
    logic                r_started;
    logic                r_upper;

    logic [WORD_BITS-1:0]  w_lo;
    logic                  w_neg;
    logic [WORD_BITS-1:0]  w_mag;
    logic [CHAIN_BITS-1:0] w_load;
    logic                  w_op_ok;
    t_cell_ctl             w_ctl;
    logic [3:0]            w_dig  [NCELL];
    logic                  w_bout [NCELL];
    logic [3:0]            w_top;
    logic                  w_emit;

    assign busy = (r_state != ST_IDLE);

    // operand preparation at accept
    assign w_lo    = i_item.value[WORD_BITS-1:0];
    assign w_neg   = (i_item.op == OP_SDEC) && w_lo[WORD_BITS-1];
    assign w_mag   = w_neg ? (WORD_BITS'(0) - w_lo) : w_lo;
    assign w_op_ok = (i_item.op <= OP_PTR);

    // parallel nibbles for the hex formats; decimal starts from all-zero cells
    always_comb begin
        w_load = '0;
        unique case (i_item.op)
            OP_HEXL, OP_HEXU: w_load[WORD_BITS-1:0] = w_lo;
            OP_PTR:           w_load[POINTER_BITS-1:0] = i_item.value[POINTER_BITS-1:0];
            default:          w_load = '0;
        endcase
    end

    // row command
    always_comb begin
        w_ctl.load  = (r_state == ST_IDLE) && start && w_op_ok;
        w_ctl.conv  = (r_state == ST_CONV);
        w_ctl.shift = (r_state == ST_DIG);
    end

    // row of digit cells; bits and digits move up toward the top cell
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        logic       w_bin;
        logic [3:0] w_din;
        if (g == 0) begin : g_first
            assign w_bin = r_bin[WORD_BITS-1];
            assign w_din = 4'd0;
        end else begin : g_rest
            assign w_bin = w_bout[g-1];
            assign w_din = w_dig[g-1];
        end
        i2a_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_load_digit (w_load[4*g +: 4]),
            .i_bit        (w_bin),
            .i_digit      (w_din),
            .o_bit        (w_bout[g]),
            .o_digit      (w_dig[g])
        );
    end

    // leading zeros are dropped, but the final position always prints
    assign w_top  = w_dig[NCELL-1];
    assign w_emit = r_started || (w_top != 4'd0) || (r_left == LEFT_W'(1));

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_bin     <= w_mag;
                        r_bits    <= '1;
                        r_left    <= LEFT_W'(NCELL);
                        r_started <= 1'b0;
                        r_upper   <= (i_item.op == OP_HEXU);
                        r_count   <= '0;
                        unique case (i_item.op)
                            OP_SDEC, OP_UDEC: begin
                                r_state <= ST_CONV;
                                if (w_neg) begin
                                    o_strobe            <= 1'b1;
                                    o_result.character  <= CH_MINUS;
                                    o_result.last       <= 1'b0;
                                    o_result.char_count <= CNT_W'(1);
                                    r_count             <= CNT_W'(1);
                                end
                            end
                            OP_HEXL, OP_HEXU: begin
                                r_state <= ST_DIG;
                            end
                            OP_PTR: begin
                                r_state             <= ST_PFX;
                                o_strobe            <= 1'b1;
                                o_result.character  <= CH_ZERO;
                                o_result.last       <= 1'b0;
                                o_result.char_count <= CNT_W'(1);
                                r_count             <= CNT_W'(1);
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_CONV: begin
                    r_bin  <= r_bin << 1;
                    r_bits <= r_bits - 1'b1;
                    if (r_bits == '0) begin
                        r_state <= ST_DIG;
                    end
                end
                ST_PFX: begin
                    o_strobe            <= 1'b1;
                    o_result.character  <= CH_X;
                    o_result.last       <= 1'b0;
                    o_result.char_count <= r_count + 1'b1;
                    r_count             <= r_count + 1'b1;
                    r_state             <= ST_DIG;
                end
                ST_DIG: begin
                    r_left <= r_left - 1'b1;
                    if (w_emit) begin
                        o_strobe            <= 1'b1;
                        o_result.character  <= digit_char(w_top, r_upper);
                        o_result.last       <= (r_left == LEFT_W'(1));
                        o_result.char_count <= r_count + 1'b1;
                        r_count             <= r_count + 1'b1;
                        r_started           <= 1'b1;
                    end
                    if (r_left == LEFT_W'(1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // the final digit position always closes the run with a last beat
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIG && r_left == LEFT_W'(1)) |=> (o_strobe && o_result.last))
        else $error("final digit position did not produce a last beat");

    // a last beat leaves the block free for the next number
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |-> !busy)
        else $error("busy still high on last beat");

    // a count stays within one run's length
    a_count_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.char_count != '0 && o_result.char_count <= CNT_W'(18)))
        else $error("character count out of range");

    // an unused selector produces nothing and keeps the block idle
    a_bad_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.op > OP_PTR) |=> (!busy && !o_strobe))
        else $error("unused selector started a run");

endmodule

[rtl/i2a_cell.sv]
// i2a_cell: one 4-bit digit cell of the conversion row.
// Depends on i2a_pkg (t_cell_ctl).
module i2a_cell (
    input  logic              i_clk,
    input  i2a_pkg::t_cell_ctl i_ctl,
    input  logic [3:0]        i_load_digit,
    input  logic              i_bit,
    input  logic [3:0]        i_digit,
    output logic              o_bit,
    output logic [3:0]        o_digit
);
    import i2a_pkg::*;

    logic [3:0] r_digit;
    logic [3:0] w_adj;

    // double-dabble correction: a digit of 5 or more gets 3 added before the shift
    always_comb begin
        w_adj = (i_ctl.conv && r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    end

    assign o_bit   = w_adj[3];
    assign o_digit = r_digit;

    // digit register; holds while the row is idle
    always_ff @(posedge i_clk) begin
        priority if (i_ctl.load) begin
            r_digit <= i_load_digit;
        end else if (i_ctl.conv) begin
            r_digit <= {w_adj[2:0], i_bit};
        end else if (i_ctl.shift) begin
            r_digit <= i_digit;
        end else begin
            r_digit <= r_digit;
        end
    end

endmodule

[dv/i2a_checker.sv]
// i2a_checker: predicts the ASCII characters of every accepted number and compares
// them with the formatter's character beats. Depends on i2a_pkg for types and codes.
module i2a_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  i2a_pkg::t_in  i_item,
    input  logic          i_strobe,
    input  i2a_pkg::t_out i_result,
    output int            o_mismatches,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import i2a_pkg::*;

    // Only the low POINTER_BITS bits of a pointer are printed
    localparam logic [63:0] PTR_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - POINTER_BITS);

    t_out expected_chars[$];
    int   mismatch_cnt = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    // Builds the full character run for one number and queues one beat per character
    function automatic void predict_text(input t_in item);
        logic [7:0]  text[$];
        logic [7:0]  digits[$];
        logic [31:0] lo;
        logic [63:0] mag;
        logic [63:0] radix;
        logic [3:0]  d;
        logic        upper;
        t_out        beat;
        lo    = item.value[31:0];
        mag   = {32'b0, lo};
        radix = 64'd10;
        upper = 1'b0;
        case (item.op)
            OP_SDEC: begin
                if (lo[31]) begin
                    text.push_back(CH_MINUS);
                    lo  = ~lo + 32'd1;
                    mag = {32'b0, lo};
                end
            end
            OP_UDEC: ;
            OP_HEXL: radix = 64'd16;
            OP_HEXU: begin
                radix = 64'd16;
                upper = 1'b1;
            end
            OP_PTR: begin
                text.push_back(CH_ZERO);
                text.push_back(CH_X);
                mag   = item.value & PTR_MASK;
                radix = 64'd16;
            end
            default: return;  // unused selectors print nothing
        endcase
        // Least significant digit first, prepended so the run reads msd first
        do begin
            d = 4'(mag % radix);
            if (d < 4'd10) begin
                digits.push_front(CH_ZERO + 8'(d));
            end else begin
                digits.push_front((upper ? CH_A_UP : CH_A_LO) + 8'(d) - 8'd10);
            end
            mag = mag / radix;
        end while (mag != 64'd0);
        foreach (digits[i]) text.push_back(digits[i]);
        foreach (text[i]) begin
            beat.character  = text[i];
            beat.last       = (i == text.size() - 1);
            beat.char_count = CNT_W'(i + 1);
            expected_chars.push_back(beat);
        end
    endfunction

    // Compare before predicting so a beat never matches an item accepted on the same edge
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_strobe) begin
                if (expected_chars.size() == 0) begin
                    if (mismatch_cnt < 10) begin
                        $display("%0t: unexpected char beat %h last=%0b count=%0d", $realtime,
                                 i_result.character, i_result.last, i_result.char_count);
                    end
                    mismatch_cnt++;
                end else begin
                    want = expected_chars.pop_front();
                    if (i_result.character !== want.character || i_result.last !== want.last
                            || i_result.char_count !== want.char_count) begin
                        if (mismatch_cnt < 10) begin
                            $display("%0t: char beat exp %h/%0b/%0d got %h/%0b/%0d", $realtime,
                                     want.character, want.last, want.char_count,
                                     i_result.character, i_result.last, i_result.char_count);
                        end
                        mismatch_cnt++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                predict_text(i_item);
            end
        end
        o_mismatches <= mismatch_cnt;
        o_pending    <= expected_chars.size();
    end

endmodule

[dv/tb_integer_to_ascii_formatter.sv]
// tb_integer_to_ascii_formatter: drives numbers in bursts into the formatter and gives
// the verdict. Depends on i2a_pkg, integer_to_ascii_formatter and i2a_checker.
module tb_integer_to_ascii_formatter;
    timeunit 1ns;
    timeprecision 1ps;

    import i2a_pkg::*;

    // Selector codes the block leaves unused
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam int RANDOM_ITEMS = 310;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 64;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_item;
    logic o_strobe;
    t_out o_result;
    int   mismatch_total;
    int   char_backlog;
    int   idle_cycles = 0;

    integer_to_ascii_formatter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    i2a_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_mismatches (mismatch_total),
        .o_pending    (char_backlog)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog: no number accepted and no character out for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one number and hold it until the block takes it
    task automatic send_num(input logic [2:0] op, input logic [63:0] value);
        i_item <= '{op: op, value: value};
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    // Wait until every predicted character has come out and the block is idle
    task automatic wait_drained();
        do @(posedge i_clk); while (char_backlog != 0 || busy);
    endtask

    function automatic logic [2:0] random_op();
        if ($urandom_range(0, 19) == 0) begin
            return 3'($urandom_range(OP_RSVD5, OP_RSVD7));
        end
        return 3'($urandom_range(OP_SDEC, OP_PTR));
    endfunction

    // Mix of full-width, shortened, tiny and sign-boundary values
    function automatic logic [63:0] random_value();
        logic [63:0] full;
        full = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return full;
            1: return full >> $urandom_range(1, 63);
            2: return {full[63:32], 32'($urandom_range(0, 20))};
            default: begin
                case ($urandom_range(0, 3))
                    0: return {full[63:32], 32'h8000_0000};
                    1: return {full[63:32], 32'h7FFF_FFFF};
                    2: return {full[63:32], 32'hFFFF_FFFF};
                    default: return 64'd1 << $urandom_range(0, 63);
                endcase
            end
        endcase
    endfunction

    initial begin
        int sent;
        int burst;
        int gap;
        bit drain;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every format, most negative, zeros, unused selectors
        send_num(OP_SDEC, 64'd0);
        send_num(OP_SDEC, 64'h0000_0000_8000_0000);
        send_num(OP_SDEC, 64'hFFFF_FFFF_7FFF_FFFF);
        send_num(OP_SDEC, 64'h1234_5678_FFFF_FFFF);
        send_num(OP_SDEC, 64'd9);
        send_num(OP_UDEC, 64'd0);
        send_num(OP_UDEC, 64'hFFFF_FFFF_FFFF_FFFF);
        send_num(OP_UDEC, 64'h0000_0000_8000_0000);
        send_num(OP_UDEC, 64'd10);
        send_num(OP_HEXL, 64'd0);
        send_num(OP_HEXL, 64'hFFFF_FFFF_FFFF_FFFF);
        send_num(OP_HEXL, 64'hAAAA_5555_DEAD_BEEF);
        send_num(OP_HEXU, 64'd0);
        send_num(OP_HEXU, 64'h0000_0000_ABCD_EF01);
        send_num(OP_HEXU, 64'hFFFF_FFFF_0000_000F);
        send_num(OP_PTR, 64'd0);
        send_num(OP_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
        send_num(OP_PTR, 64'h8000_0000_0000_0000);
        send_num(OP_PTR, 64'h0000_0001_0000_0000);
        send_num(OP_PTR, 64'd1);
        send_num(OP_RSVD5, 64'hFFFF_FFFF_FFFF_FFFF);
        send_num(OP_RSVD6, 64'd0);
        send_num(OP_RSVD7, 64'h0123_4567_89AB_CDEF);
        start <= 1'b0;
        wait_drained();

        // Random bursts with random gaps and an occasional full drain
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 8);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                send_num(random_op(), random_value());
                sent++;
            end
            gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            drain = ($urandom_range(0, 11) == 0);
            if (gap != 0 || drain) begin
                start <= 1'b0;
                if (gap != 0) repeat (gap) @(posedge i_clk);
                if (drain) wait_drained();
            end
        end
        start <= 1'b0;

        // Let the last number finish, then allow for a stray late beat
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_total == 0 && char_backlog == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
